[design/rg32ph_pkg.sv]
// Shared types, constants and round/character functions for the RadioGatun[32] password hash.
package rg32ph_pkg;

  localparam int MILL_LEN    = 19;
  localparam int BELT_LEN    = 40;
  localparam int BELT_COLS   = 13;
  localparam int BLOCK_BYTES = 12;

  localparam logic [15:0] COST_LIMIT   = 16'd9999;
  localparam logic [16:0] SHORT_BLANKS = 17'd17;
  localparam logic [15:0] COST_RESET   = 16'd32768;
  localparam logic [5:0]  WORDS_RESET  = 6'd22;
  localparam logic [5:0]  MAX_WORDS    = 6'd32;
  localparam logic [7:0]  PAD_BYTE     = 8'h01;

  // configuration register indexes
  localparam logic CFG_BLANK_COST = 1'b0;
  localparam logic CFG_WORD_COUNT = 1'b1;

  // alphabet breakpoints: 0-9 @ A-Z a-z .
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_UPZ   = 8'd90;
  localparam logic [7:0] CHAR_LOWZ  = 8'd122;
  localparam logic [7:0] CHAR_GAP   = 8'd6;
  localparam logic [7:0] CHAR_WRAP  = 8'd77;

  typedef logic [MILL_LEN-1:0][31:0] mill_t;
  typedef logic [BELT_LEN-1:0][31:0] belt_t;

  typedef struct packed {
    mill_t mill;
    belt_t belt;
  } rg_state_t;

  typedef struct packed {
    logic absorb;  // xor data byte at the current position
    logic pad;     // xor pad byte at the current position
    logic round;   // run one round
    logic clear;   // clear mill, belt and byte position
    logic load;    // load the output register
    logic sel2;    // output mill word 2 instead of word 1
    logic last;    // final word of the message
  } dp_cmd_t;

  typedef struct packed {
    logic pos_wrap;  // an absorbed byte at this position fills the block
  } dp_status_t;

  // One RadioGatun[32] round: belt feedforward, mill gamma/pi/theta/iota,
  // belt shift, belt-to-mill injection.
  function automatic rg_state_t rg_round(rg_state_t s);
    rg_state_t n;
    belt_t     fb;
    mill_t     g;
    logic [31:0] x;
    logic [63:0] xx;
    int i, m3, p, p1, p2, r, i1, i4;
    fb = s.belt;
    m3 = 0;
    for (i = 0; i < 12; i++) begin
      fb[i + m3 * BELT_COLS] = fb[i + m3 * BELT_COLS] ^ s.mill[i + 1];
      m3 = (m3 == 2) ? 0 : m3 + 1;
    end
    p = 0;
    r = 0;
    for (i = 0; i < MILL_LEN; i++) begin
      p1 = (p + 1 >= MILL_LEN) ? p + 1 - MILL_LEN : p + 1;
      p2 = (p1 + 1 >= MILL_LEN) ? p1 + 1 - MILL_LEN : p1 + 1;
      x = s.mill[p] ^ (s.mill[p1] | ~s.mill[p2]);
      r = (r + i) & 31;
      xx = {x, x} >> r;
      g[i] = xx[31:0];
      p = p + 7;
      if (p >= MILL_LEN) p = p - MILL_LEN;
    end
    n.belt[0] = fb[0];
    for (i = 1; i < BELT_LEN; i++) begin
      n.belt[i] = fb[i - 1];
    end
    for (i = 0; i < MILL_LEN; i++) begin
      i1 = (i + 1 >= MILL_LEN) ? i + 1 - MILL_LEN : i + 1;
      i4 = (i + 4 >= MILL_LEN) ? i + 4 - MILL_LEN : i + 4;
      n.mill[i] = g[i] ^ g[i1] ^ g[i4];
    end
    n.mill[0] = n.mill[0] ^ 32'd1;
    for (i = 0; i < 3; i++) begin
      n.belt[i * BELT_COLS] = n.belt[i * BELT_COLS + BELT_COLS];
      n.mill[i + 13] = n.mill[i + 13] ^ n.belt[i * BELT_COLS];
    end
    return n;
  endfunction

  function automatic logic [6:0] to_char(logic [31:0] v);
    logic [7:0] b;
    b = {2'b00, v[5:0]} + CHAR_ZERO;
    if (b > CHAR_NINE) b = b + CHAR_GAP;
    if (b > CHAR_UPZ) b = b + CHAR_GAP;
    if (b > CHAR_LOWZ) b = b - CHAR_WRAP;
    return b[6:0];
  endfunction

endpackage

[design/radiogatun32_password_hash.sv]
// Top level of the RadioGatun[32] password hash engine.
// Message bytes (salt prefix, then password) arrive one item per accepted cycle and
// are XORed little-endian into belt row 0 and mill words 16..18. A byte that
// completes a 12-byte block is followed by a round, during which in_stall is
// high. After the byte marked last_byte the engine pads with 0x01, runs blank
// rounds (blank_cost+1 of them when blank_cost exceeds 9999, otherwise 17), then
// squeezes output_word_count words (0 means 1, above 32 means 32): one round, then
// mill word 1 and mill word 2 as two result items. Every round runs in the single
// round unit, and in_stall stays high throughout a message's tail, also while the
// output is stalled. Each result carries the word, its character from the alphabet
// 0-9 @ A-Z a-z . and last_word on the final one. The state clears as the last
// word is loaded, and the next message may start while that word still waits in
// the output register. Configuration is a plain write port (index 0 blank_cost,
// index 1 output_word_count); the user must write it only while idle, which the
// block itself does not enforce.
module radiogatun32_password_hash (
  input  logic        clk,
  input  logic        rst,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] hash_word,
  output logic [6:0]  hash_char,
  output logic        last_word,
  // configuration writes
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import rg32ph_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing, config registers and output valid
  rg32ph_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd)
  );

  // mill, belt, round unit and output payload register
  rg32ph_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (data_byte),
    .status    (status),
    .hash_word (hash_word),
    .hash_char (hash_char),
    .last_word (last_word)
  );

endmodule

[design/rg32ph_datapath.sv]
// Datapath: mill and belt state, byte injection, round unit and output register.
module rg32ph_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  rg32ph_pkg::dp_cmd_t    cmd,
  input  logic [7:0]             data_byte,
  output rg32ph_pkg::dp_status_t status,
  output logic [31:0]            hash_word,
  output logic [6:0]             hash_char,
  output logic                   last_word
);
  import rg32ph_pkg::*;

  rg_state_t   st;
  rg_state_t   st_next;
  rg_state_t   st_round;
  logic [3:0]  pos;
  logic [3:0]  pos_next;
  logic [7:0]  inj_byte;
  logic [31:0] inj_word;
  logic [31:0] out_word;

  assign st_round = rg_round(st);
  assign status.pos_wrap = (pos == 4'(BLOCK_BYTES - 1));
  assign out_word = cmd.sel2 ? st.mill[2] : st.mill[1];

  always_comb begin
    inj_byte = cmd.pad ? PAD_BYTE : data_byte;
    inj_word = {24'd0, inj_byte} << {pos[1:0], 3'b000};
    st_next  = st;
    pos_next = pos;
    if (cmd.clear) begin
      st_next  = '0;
      pos_next = '0;
    end else if (cmd.round) begin
      st_next = st_round;
    end else if (cmd.absorb || cmd.pad) begin
      for (int k = 0; k < 3; k++) begin
        if (pos[3:2] == 2'(k)) begin
          st_next.belt[k * BELT_COLS] = st.belt[k * BELT_COLS] ^ inj_word;
          st_next.mill[16 + k] = st.mill[16 + k] ^ inj_word;
        end
      end
      if (cmd.absorb) begin
        pos_next = status.pos_wrap ? 4'd0 : pos + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= '0;
      pos <= '0;
    end else begin
      st  <= st_next;
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hash_word <= out_word;
      hash_char <= to_char(out_word);
      last_word <= cmd.last;
    end
  end

endmodule

[design/rg32ph_ctrl.sv]
// Controller: configuration registers, sequencing of absorb, pad, blank and squeeze rounds.
module rg32ph_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   last_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  logic                   cfg_write,
  input  logic                   cfg_index,
  input  logic [15:0]            cfg_data,
  input  rg32ph_pkg::dp_status_t status,
  output rg32ph_pkg::dp_cmd_t    cmd
);
  import rg32ph_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_BLOCK    = 3'd1;
  localparam logic [2:0] S_PAD      = 3'd2;
  localparam logic [2:0] S_BLANK    = 3'd3;
  localparam logic [2:0] S_SQ_ROUND = 3'd4;
  localparam logic [2:0] S_WORD1    = 3'd5;
  localparam logic [2:0] S_WORD2    = 3'd6;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic        last_q;
  logic        last_q_next;
  logic [16:0] round_count;
  logic [16:0] round_count_next;
  logic [5:0]  words_left;
  logic [5:0]  words_left_next;
  logic        out_valid_next;
  logic [15:0] blank_cost;
  logic [5:0]  word_count;
  logic [5:0]  words_clamped;
  logic [16:0] blanks;
  logic        in_accept;
  logic        out_free;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign blanks = (blank_cost > COST_LIMIT) ? ({1'b0, blank_cost} + 17'd1) : SHORT_BLANKS;

  always_comb begin
    if (word_count == 6'd0) words_clamped = 6'd1;
    else if (word_count > MAX_WORDS) words_clamped = MAX_WORDS;
    else words_clamped = word_count;
  end

  always_comb begin
    state_next       = state;
    last_q_next      = last_q;
    round_count_next = round_count;
    words_left_next  = words_left;
    cmd              = '0;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          cmd.absorb  = 1'b1;
          last_q_next = last_byte;
          if (status.pos_wrap) state_next = S_BLOCK;
          else if (last_byte) state_next = S_PAD;
        end
      end
      S_BLOCK: begin
        cmd.round  = 1'b1;
        state_next = last_q ? S_PAD : S_IDLE;
      end
      S_PAD: begin
        cmd.pad          = 1'b1;
        round_count_next = blanks;
        words_left_next  = words_clamped;
        state_next       = S_BLANK;
      end
      S_BLANK: begin
        cmd.round        = 1'b1;
        round_count_next = round_count - 17'd1;
        if (round_count == 17'd1) state_next = S_SQ_ROUND;
      end
      S_SQ_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_WORD1;
      end
      S_WORD1, S_WORD2: begin
        if (out_free) begin
          cmd.load        = 1'b1;
          cmd.sel2        = (state == S_WORD2);
          cmd.last        = (words_left == 6'd1);
          words_left_next = words_left - 6'd1;
          if (words_left == 6'd1) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = (state == S_WORD1) ? S_WORD2 : S_SQ_ROUND;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load) out_valid_next = 1'b1;
    else if (!out_stall) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      last_q      <= 1'b0;
      round_count <= '0;
      words_left  <= '0;
      out_valid   <= 1'b0;
      blank_cost  <= COST_RESET;
      word_count  <= WORDS_RESET;
    end else begin
      state       <= state_next;
      last_q      <= last_q_next;
      round_count <= round_count_next;
      words_left  <= words_left_next;
      out_valid   <= out_valid_next;
      if (cfg_write) begin
        case (cfg_index)
          CFG_BLANK_COST: blank_cost <= cfg_data;
          CFG_WORD_COUNT: word_count <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_blank_count: assert property (@(posedge clk) disable iff (rst)
    state == S_BLANK |-> round_count != 17'd0)
    else $error("blank round with zero count");

  a_words_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_WORD1 || state == S_WORD2) |-> words_left != 6'd0)
    else $error("squeeze with no words left");

  a_last_to_pad: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last_byte && !status.pos_wrap) |=> state == S_PAD)
    else $error("last byte did not start padding");

  a_pad_load: assert property (@(posedge clk) disable iff (rst)
    state == S_PAD |=> (state == S_BLANK && round_count >= SHORT_BLANKS))
    else $error("blank count not loaded after pad");
`endif

endmodule

[tb/radiogatun32_password_hash_tb.sv]
// Self-checking testbench for the RadioGatun[32] password hash engine.
module radiogatun32_password_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rg32ph_pkg::*;

  localparam int CYCLE_LIMIT   = 20000000;
  localparam int TARGET_BYTES  = 310;
  localparam int LONG_HOLD     = 400;   // receiver hold-off under pressure
  localparam int MAX_WAIT      = 17;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  typedef struct {
    logic [31:0] word;
    logic [6:0]  chr;
    logic        last;
  } hash_result_t;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  // block inputs, all known from time zero
  logic        in_valid  = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_stall = 1'b0;
  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_BLANK_COST;
  logic [15:0] cfg_data  = 16'h0000;

  // block outputs
  logic        in_stall;
  logic        out_valid;
  logic [31:0] hash_word;
  logic [6:0]  hash_char;
  logic        last_word;

  radiogatun32_password_hash dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hash_word (hash_word),
    .hash_char (hash_char),
    .last_word (last_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------
  // Predictor: its own copy of the hash state and the two settings.
  // ---------------------------------------------------------------------
  logic [31:0] mill [MILL_LEN];
  logic [31:0] belt [BELT_LEN];
  int          fill_pos;        // next byte slot within the 12-byte block
  logic [1:0]  out_phase;       // bit 1 set: a round is due before the next word
  logic [15:0] cost_setting;
  logic [5:0]  word_setting;

  hash_result_t words_due [$];  // expected result items, oldest first
  msg_byte_t    pending_bytes [$];

  int bytes_queued   = 0;
  int bytes_accepted = 0;
  int mismatches     = 0;
  int cycle_count    = 0;

  bit byte_taken     = 1'b0;    // handshakes seen at the last rising edge
  bit word_taken     = 1'b0;
  bit sender_quiet   = 1'b0;    // no gaps between items
  bit receiver_quiet = 1'b0;    // no stalls between results
  bit hold_go        = 1'b0;
  logic receiver_hold = 1'b0;

  function automatic void clear_hash_state();
    for (int i = 0; i < MILL_LEN; i++) mill[i] = '0;
    for (int i = 0; i < BELT_LEN; i++) belt[i] = '0;
    fill_pos  = 0;
    out_phase = 2'b10;
  endfunction

  // One full round: belt feedforward, mill nonlinearity and diffusion,
  // belt rotation, then belt-to-mill injection.
  function automatic void mix_round();
    logic [31:0] g [MILL_LEN];
    logic [31:0] x;
    int          r;
    int          p;
    for (int i = 0; i < 12; i++)
      belt[i + (i % 3) * BELT_COLS] ^= mill[i + 1];
    r = 0;
    for (int i = 0; i < MILL_LEN; i++) begin
      p = (i * 7) % MILL_LEN;
      x = mill[p] ^ (mill[(p + 1) % MILL_LEN] | ~mill[(p + 2) % MILL_LEN]);
      r = (r + i) % 32;
      // a shift by 32 gives zero, so r == 0 leaves x unchanged
      g[i] = (x >> r) | (x << (32 - r));
    end
    for (int j = BELT_LEN - 1; j > 0; j--) belt[j] = belt[j - 1];
    for (int i = 0; i < MILL_LEN; i++)
      mill[i] = g[i] ^ g[(i + 1) % MILL_LEN] ^ g[(i + 4) % MILL_LEN];
    mill[0] ^= 32'd1;
    for (int i = 0; i < 3; i++) begin
      belt[i * BELT_COLS] = belt[i * BELT_COLS + BELT_COLS];
      mill[i + 13] ^= belt[i * BELT_COLS];
    end
  endfunction

  // 0-9, '@', A-Z, a-z, '.' for the low six bits
  function automatic logic [6:0] alphabet_char(logic [31:0] v);
    logic [7:0] c;
    c = {2'b00, v[5:0]} + 8'h30;
    if (c > 8'h39) c = c + 8'd6;
    if (c > 8'h5a) c = c + 8'd6;
    if (c > 8'h7a) c = c - 8'd77;
    return c[6:0];
  endfunction

  // xor a byte into belt row 0 and the matching mill word, little-endian
  function automatic void xor_lane(logic [7:0] v, int slot);
    logic [31:0] lane;
    lane = 32'(v) << (8 * (slot % 4));
    belt[(slot / 4) * BELT_COLS] ^= lane;
    mill[16 + slot / 4] ^= lane;
  endfunction

  // Absorb one accepted item; on the final byte pad, run the blank rounds
  // and queue every squeezed word.
  function automatic void hash_byte(logic [7:0] v, logic final_byte);
    int           blanks;
    int           n;
    hash_result_t res;
    xor_lane(v, fill_pos);
    fill_pos++;
    if (fill_pos == BLOCK_BYTES) begin
      mix_round();
      fill_pos = 0;
    end
    if (!final_byte) return;
    // a full block was already flushed above, so the pad lands in slot 0 then
    xor_lane(PAD_BYTE, fill_pos);
    blanks = (cost_setting > COST_LIMIT) ? int'(cost_setting) + 1 : int'(SHORT_BLANKS);
    repeat (blanks) mix_round();
    // zero words means one, anything past the maximum is clamped
    n = (word_setting == 0) ? 1 : ((word_setting > MAX_WORDS) ? int'(MAX_WORDS)
                                                               : int'(word_setting));
    for (int k = 0; k < n; k++) begin
      if (out_phase[1]) mix_round();
      out_phase ^= 2'b11;
      res.word = mill[out_phase];
      res.chr  = alphabet_char(res.word);
      res.last = (k == n - 1);
      words_due.push_back(res);
    end
    clear_hash_state();
  endfunction

  function automatic int draw_wait(bit quiet);
    if (quiet) return 0;
    // mostly short waits, now and then a long one
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : $urandom_range(0, 2);
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: both handshakes are sampled at the rising edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : watch_edges
    hash_result_t got;
    hash_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end else begin
      byte_taken = !rst && in_valid && !in_stall;
      word_taken = !rst && out_valid && !out_stall;
      if (byte_taken) begin
        hash_byte(data_byte, last_byte);
        bytes_accepted++;
      end
      if (word_taken) begin
        got.word = hash_word;
        got.chr  = hash_char;
        got.last = last_word;
        if (words_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: word %h char %h last %b", got.word, got.chr,
                     got.last);
        end else begin
          want = words_due.pop_front();
          if (got.word !== want.word || got.chr !== want.chr || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected word %h char %h last %b, got word %h char %h last %b",
                       want.word, want.chr, want.last, got.word, got.chr, got.last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender: inputs change at the falling edge. A new item replaces the
  // current one only once it was taken; a random gap follows each.
  // ---------------------------------------------------------------------
  int gap_left = 0;

  always @(negedge clk) begin : drive_bytes
    msg_byte_t nxt;
    if (!rst && (!in_valid || byte_taken)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_bytes.size() != 0) begin
        nxt = pending_bytes.pop_front();
        data_byte <= nxt.data;
        last_byte <= nxt.last;
        in_valid  <= 1'b1;
        gap_left  <= draw_wait(sender_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls for a random wait after each result, or
  // throughout the long hold-off.
  int stall_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (word_taken) stall_left = draw_wait(receiver_quiet);
      if (receiver_hold) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Long hold-off: the output backs up and the block has to stall its input.
  initial begin
    wait (hold_go);
    @(negedge clk);
    receiver_hold <= 1'b1;
    repeat (LONG_HOLD) @(negedge clk);
    receiver_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic write_reg(logic idx, logic [15:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == CFG_BLANK_COST) cost_setting = value;
    else word_setting = value[5:0];
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] cost, logic [15:0] words);
    write_reg(CFG_BLANK_COST, cost);
    write_reg(CFG_WORD_COUNT, words);
    @(posedge clk);
  endtask

  task automatic send_message(int len, fill_t fill);
    msg_byte_t b;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: b.data = 8'h00;
        FILL_ONES: b.data = 8'hff;
        default:   b.data = 8'($urandom_range(0, 255));
      endcase
      b.last = (i == len - 1);
      pending_bytes.push_back(b);
      bytes_queued++;
    end
  endtask

  // every item taken and every result back, then a wait for the
  // round that a block-completing byte may still be running
  task automatic drain();
    while (bytes_accepted != bytes_queued || words_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int pick_length();
    // favor lengths around block boundaries
    case ($urandom_range(0, 5))
      0:       return 11 + $urandom_range(0, 2);
      1:       return 23 + $urandom_range(0, 2);
      2:       return 1 + $urandom_range(0, 3);
      default: return $urandom_range(1, 30);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Main flow
  // ---------------------------------------------------------------------
  initial begin : main_flow
    logic [15:0] cost;
    logic [15:0] words;
    int          msgs;

    cost_setting = COST_RESET;
    word_setting = WORDS_RESET;
    clear_hash_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: one-byte all-zero message, long blank stretch
    send_message(1, FILL_ZERO);
    drain();

    // no cost, single word; block fills exactly on the last byte
    set_config(16'd0, 16'd1);
    send_message(12, FILL_ONES);
    drain();

    // highest short cost, most words; pad goes in the block's last slot
    set_config(COST_LIMIT, 16'(MAX_WORDS));
    send_message(11, FILL_RANDOM);
    drain();

    // first long cost, zero words read as one
    set_config(COST_LIMIT + 16'd1, 16'd0);
    send_message(1, FILL_RANDOM);
    drain();

    // top cost, word count past the maximum (upper data bits set too)
    set_config(16'hffff, 16'hffe1);
    send_message(1, FILL_ONES);
    drain();

    // pressure: sender keeps offering while the receiver holds off
    set_config(16'd0, 16'(MAX_WORDS));
    sender_quiet = 1'b1;
    receiver_quiet = 1'b1;
    hold_go = 1'b1;
    for (int m = 0; m < 6; m++) send_message($urandom_range(1, 5), FILL_RANDOM);
    drain();

    // random phases
    while (bytes_queued < TARGET_BYTES) begin
      case ($urandom_range(0, 9))
        0:       cost = 16'd0;
        1:       cost = COST_LIMIT;
        2:       cost = COST_LIMIT + 16'($urandom_range(1, 300));
        default: cost = 16'($urandom_range(0, int'(COST_LIMIT)));
      endcase
      words = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 2) != 0) words[5:0] = 6'($urandom_range(1, 32));
      set_config(cost, words);
      sender_quiet   = ($urandom_range(0, 3) == 0);
      receiver_quiet = ($urandom_range(0, 3) == 0);
      // long blank stretches get a single message
      msgs = (cost > COST_LIMIT) ? 1 : $urandom_range(1, 6);
      for (int m = 0; m < msgs; m++) begin
        if (bytes_queued < TARGET_BYTES) send_message(pick_length(), FILL_RANDOM);
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (words_due.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
design/rg32ph_pkg.sv
design/rg32ph_datapath.sv
design/rg32ph_ctrl.sv
design/radiogatun32_password_hash.sv
tb/radiogatun32_password_hash_tb.sv
